### rtl/mcg_pkg.sv
// Shared types, constants and calendar helper functions for the month calendar grid.
package mcg_pkg;

    // Grid geometry: six rows of seven columns.
    localparam int GRID_CELLS = 42;
    localparam int CELL_W     = 6;

    // Cell kinds as carried in the result.
    localparam logic [1:0] KIND_PREV = 2'd0;
    localparam logic [1:0] KIND_CUR  = 2'd1;
    localparam logic [1:0] KIND_NEXT = 2'd2;

    // Accepted calendar range.
    localparam logic [13:0] YEAR_MIN = 14'd1600;
    localparam logic [13:0] YEAR_END = 14'd7000;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    // Reciprocal multipliers for division by 100 and by 7.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [13:0] RECIP_7   = 14'd9363;

    // Everything the cell generator needs for one request.
    typedef struct packed {
        logic              err;
        logic [2:0]        weekday;
        logic [4:0]        cur_len;
        logic [4:0]        prev_len;
        logic              sel_valid;
        logic [CELL_W-1:0] sel_pos;
    } t_grid_setup;

    // Days in the year before the first of month m (non-leap).
    function automatic logic [8:0] f_days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of month m; February takes the leap flag into account.
    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] l;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
            MONTH_FEB:               l = leap ? 5'd29 : 5'd28;
            default:                 l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

### rtl/mcg_setup.sv
// Date arithmetic pipeline: range check, weekday of the first and month lengths.
module mcg_setup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [13:0]          i_year,
    input  logic [3:0]           i_month,
    input  logic [4:0]           i_sel_day,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mcg_pkg::t_grid_setup o_setup
);

    // Stage valids and the ready chain; a stage moves when the next one is free.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v4;

    // Stage 1: input register.
    logic [13:0] r_year1;
    logic [3:0]  r_month1;
    logic [4:0]  r_sel1;

    // Stage 2: range check and year divided by 100.
    logic [13:0] r_year2;
    logic [3:0]  r_month2;
    logic [4:0]  r_sel2;
    logic [7:0]  r_q2;
    logic        r_err2;
    logic [26:0] w_prod100;
    logic        w_err1;

    assign w_prod100 = {13'd0, r_year1} * {14'd0, mcg_pkg::RECIP_100};
    assign w_err1 = (r_year1 < mcg_pkg::YEAR_MIN) || (r_year1 >= mcg_pkg::YEAR_END) ||
                    (r_month1 < mcg_pkg::MONTH_JAN) || (r_month1 > mcg_pkg::MONTH_DEC);

    // Stage 3: leap year, day count sum and month lengths.
    logic [13:0] r_sum3;
    logic [4:0]  r_sel3;
    logic [4:0]  r_cur3;
    logic [4:0]  r_prev3;
    logic        r_err3;
    logic [13:0] w_rem100;
    logic        w_cent;
    logic        w_leap;
    logic [13:0] w_p;
    logic [7:0]  w_pq;
    logic [13:0] w_sum;
    logic        w_leap_add;

    assign w_rem100   = r_year2 - ({6'd0, r_q2} * 14'd100);
    assign w_cent     = (w_rem100 == 14'd0);
    assign w_leap     = ((r_year2[1:0] == 2'd0) && !w_cent) || (w_cent && (r_q2[1:0] == 2'd0));
    assign w_p        = r_year2 - 14'd1;
    assign w_pq       = r_q2 - {7'd0, w_cent};
    assign w_leap_add = (r_month2 > mcg_pkg::MONTH_FEB) && w_leap;
    assign w_sum      = w_p + (w_p >> 2) - {6'd0, w_pq} + {8'd0, w_pq[7:2]}
                      + {5'd0, mcg_pkg::f_days_before(r_month2)} + 14'd1
                      + {13'd0, w_leap_add};

    // Stage 4: sum modulo 7 gives the weekday; selected cell position follows.
    mcg_pkg::t_grid_setup r_setup4;
    logic [27:0] w_prod7;
    logic [13:0] w_rem7;
    logic [2:0]  w_wd;
    logic [5:0]  w_sel_sum;

    assign w_prod7   = {14'd0, r_sum3} * {14'd0, mcg_pkg::RECIP_7};
    assign w_rem7    = r_sum3 - ({2'd0, w_prod7[27:16]} * 14'd7);
    assign w_wd      = w_rem7[2:0];
    assign w_sel_sum = {3'd0, w_wd} + {1'b0, r_sel3};
    assign o_setup   = r_setup4;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_year1  <= i_year;
            r_month1 <= i_month;
            r_sel1   <= i_sel_day;
        end
        if (w_rdy2) begin
            r_year2  <= r_year1;
            r_month2 <= r_month1;
            r_sel2   <= r_sel1;
            r_q2     <= w_prod100[26:19];
            r_err2   <= w_err1;
        end
        if (w_rdy3) begin
            r_sum3  <= w_sum;
            r_sel3  <= r_sel2;
            r_err3  <= r_err2;
            r_cur3  <= (r_month2 == mcg_pkg::MONTH_DEC) ? 5'd31
                                                        : mcg_pkg::f_month_len(r_month2, w_leap);
            r_prev3 <= (r_month2 == mcg_pkg::MONTH_JAN) ? 5'd31
                                                        : mcg_pkg::f_month_len(r_month2 - 4'd1,
                                                                               w_leap);
        end
        if (w_rdy4) begin
            r_setup4.err       <= r_err3;
            r_setup4.weekday   <= w_wd;
            r_setup4.cur_len   <= r_cur3;
            r_setup4.prev_len  <= r_prev3;
            r_setup4.sel_valid <= (w_sel_sum != 6'd0);
            r_setup4.sel_pos   <= w_sel_sum - 6'd1;
        end
    end

endmodule

### rtl/month_calendar_grid.sv
// Top level of the month calendar grid generator.
//
// Usage: a request on the slave stream carries year, month and selected day.
// For a valid request (year 1600..6999, month 1..12) the master stream gives
// 42 cells in row-major order, Sunday first, with tlast on the final cell.
// An out-of-range request gives one result with the error bit and tlast set.
// After a request is accepted, the date arithmetic runs through a four-stage
// register pipeline (input register, divide by 100, day count, modulo 7) into
// the cell counter and then the output register.
// Output: one cell per cycle while the receiver holds tready high; a valid
// request gives 42 cells, an error request one; the cell counter sets this.
// Up to four further requests wait in the pipeline and are taken while a
// grid is still being sent, so grids follow one another without gaps.
// Reset (synchronous, active low) empties the pipeline and the output
// register; no state survives between requests.
// When the receiver holds tready low the output register keeps its cell,
// the cell counter waits, and once the pipeline has filled the request
// side's tready drops.
module month_calendar_grid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // year[13:0], month[17:14], selected_day[22:18]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // cell_index[5:0], cell_kind[7:6],
                                         // day_number[12:8], is_selected[13], error[14]
    output logic        o_m_axis_tlast
);

    localparam logic [mcg_pkg::CELL_W-1:0] LAST_CELL = mcg_pkg::CELL_W'(mcg_pkg::GRID_CELLS - 1);

    // Date arithmetic pipeline.
    logic                 w_set_valid;
    logic                 w_set_ready;
    mcg_pkg::t_grid_setup w_setup;

    mcg_setup u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_year    (i_s_axis_tdata[13:0]),
        .i_month   (i_s_axis_tdata[17:14]),
        .i_sel_day (i_s_axis_tdata[22:18]),
        .o_valid   (w_set_valid),
        .i_ready   (w_set_ready),
        .o_setup   (w_setup)
    );

    // Cell generator state.
    logic                        r_busy;
    logic [mcg_pkg::CELL_W-1:0]  r_cnt;
    mcg_pkg::t_grid_setup        r_grid;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        r_out_last;

    logic w_out_free, w_fire, w_done;

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_fire      = r_busy && w_out_free;
    assign w_done      = w_fire && (r_grid.err || (r_cnt == LAST_CELL));
    assign w_set_ready = !r_busy || w_done;

    // Cell contents for the current counter value.
    logic [5:0] w_cur_end;
    logic [5:0] w_day_prev, w_day_cur, w_day_next;
    logic [1:0] w_kind;
    logic [4:0] w_day;
    logic       w_sel;

    assign w_cur_end  = {3'd0, r_grid.weekday} + {1'b0, r_grid.cur_len};
    assign w_day_prev = {1'b0, r_grid.prev_len} - {3'd0, r_grid.weekday} + r_cnt + 6'd1;
    assign w_day_cur  = r_cnt - {3'd0, r_grid.weekday} + 6'd1;
    assign w_day_next = r_cnt - w_cur_end + 6'd1;
    assign w_sel      = r_grid.sel_valid && (r_grid.sel_pos == r_cnt);

    always_comb begin
        if (r_cnt < {3'd0, r_grid.weekday}) begin
            w_kind = mcg_pkg::KIND_PREV;
            w_day  = w_day_prev[4:0];
        end else if (r_cnt < w_cur_end) begin
            w_kind = mcg_pkg::KIND_CUR;
            w_day  = w_day_cur[4:0];
        end else begin
            w_kind = mcg_pkg::KIND_NEXT;
            w_day  = w_day_next[4:0];
        end
    end

    // Generator and output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_set_ready) begin
                r_busy <= w_set_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Generator payload and output payload.
    always_ff @(posedge i_clk) begin
        if (w_set_ready && w_set_valid) begin
            r_grid <= w_setup;
            r_cnt  <= '0;
        end else if (w_fire) begin
            r_cnt <= r_cnt + 6'd1;
        end
        if (w_fire) begin
            if (r_grid.err) begin
                r_out_data <= {1'b0, 1'b1, 14'd0};
                r_out_last <= 1'b1;
            end else begin
                r_out_data <= {1'b0, 1'b0, w_sel, w_day, w_kind, r_cnt};
                r_out_last <= (r_cnt == LAST_CELL);
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // A grid ends on its final cell.
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && !o_m_axis_tdata[14])
        |-> (o_m_axis_tdata[5:0] == LAST_CELL))
        else $error("grid ended before its final cell");

    // An error result is a single result with empty cell fields.
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[14])
        |-> (o_m_axis_tlast && (o_m_axis_tdata[13:0] == 14'd0)))
        else $error("error result malformed");

    // Cells of a grid follow one another without gaps.
    a_cell_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast)
        |=> (o_m_axis_tvalid &&
             (o_m_axis_tdata[5:0] == ($past(o_m_axis_tdata[5:0]) + 6'd1))))
        else $error("grid cell sequence broken");

    // The counter never runs past the grid.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= LAST_CELL))
        else $error("cell counter out of range");

endmodule
